// ===== rtl/core/snt_pkg.sv =====
// Shared types and constants for the sorted neighbor table.
package snt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;
    localparam int ID_W = 8;
    localparam int HOP_W = 8;
    localparam logic [ID_W-1:0] EMPTY_MARK = 8'hFF;
    localparam logic [CNT_W-1:0] MAX_COUNT = 5'd16;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_INSERT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [HOP_W-1:0] hops;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] position;
        logic [CNT_W-1:0] entry_count;
        entry_t           entry;
    } result_t;

endpackage

// ===== rtl/core/snt_ram.sv =====
// Entry store: 16 x 16-bit synchronous RAM, one read and one write port.
module snt_ram (
    input  logic              clk,
    input  snt_pkg::mem_req_t req,
    output snt_pkg::entry_t   rd_data
);
    import snt_pkg::*;

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/snt_ctrl.sv =====
// Sequencer: scans the RAM, shifts entries and inserts, builds the result.
module snt_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [snt_pkg::CNT_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 command,
    input  logic [snt_pkg::ID_W-1:0]   node_id,
    input  logic [snt_pkg::HOP_W-1:0]  hop_count,
    input  logic [snt_pkg::IDX_W-1:0]  slot,
    input  logic                       out_free,
    output logic                       res_load,
    output snt_pkg::result_t           result,
    output snt_pkg::mem_req_t          mem_req,
    input  snt_pkg::entry_t            rd_data
);
    import snt_pkg::*;

    state_t state_reg, state_next;

    cmd_t             cmd_reg;
    logic [ID_W-1:0]  id_reg;
    logic [HOP_W-1:0] hops_reg;
    logic [IDX_W-1:0] slot_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] usable;

    logic [CNT_W-1:0] scan_idx_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] found_pos_reg;
    logic [CNT_W-1:0] ins_pos_reg;

    logic             ok_reg;
    logic [IDX_W-1:0] pos_reg;
    entry_t           ent_reg;

    logic [IDX_W-1:0] sh_src_reg;
    logic [CNT_W-1:0] sh_left_reg;
    logic             wpend_reg;
    logic [IDX_W-1:0] waddr_reg;

    logic scan_issue, scan_done, hit, less, add_ok, go_shift, sh_issue, sh_done;
    logic final_ok;

    assign usable     = (cap_reg > MAX_COUNT) ? MAX_COUNT : cap_reg;
    assign scan_issue = scan_idx_reg < count_reg;
    assign scan_done  = !scan_issue && !pend_reg;
    assign hit        = pend_reg && ((cmd_reg == CMD_READ) ? (pend_idx_reg == slot_reg)
                                                           : (rd_data.id == id_reg));
    // entry sorts before the new key: hops first, then id
    assign less       = pend_reg && ((rd_data.hops < hops_reg) ||
                        ((rd_data.hops == hops_reg) && (rd_data.id < id_reg)));
    assign add_ok     = (id_reg != EMPTY_MARK) && (count_reg < usable) && !found_reg;
    assign go_shift   = ((cmd_reg == CMD_ADD) && add_ok) ||
                        ((cmd_reg == CMD_REMOVE) && found_reg);
    assign final_ok   = (cmd_reg == CMD_ADD) ? add_ok : found_reg;
    assign sh_issue   = sh_left_reg != '0;
    assign sh_done    = !sh_issue && !wpend_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = go_shift ? ST_SHIFT : ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (sh_done)
                begin
                    state_next = (cmd_reg == CMD_ADD) ? ST_INSERT : ST_DONE;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        res_load = 1'b0;
        mem_req  = '0;
        case (state_reg)
            ST_SCAN:
            begin
                mem_req.rd_en   = scan_issue;
                mem_req.rd_addr = scan_idx_reg[IDX_W-1:0];
            end
            ST_SHIFT:
            begin
                mem_req.rd_en   = sh_issue;
                mem_req.rd_addr = sh_src_reg;
                mem_req.wr_en   = wpend_reg;
                mem_req.wr_addr = waddr_reg;
                mem_req.wr_data = rd_data;
            end
            ST_INSERT:
            begin
                mem_req.wr_en        = 1'b1;
                mem_req.wr_addr      = pos_reg;
                mem_req.wr_data.id   = id_reg;
                mem_req.wr_data.hops = hops_reg;
            end
            ST_DONE:
            begin
                res_load = out_free;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    assign result.ok          = ok_reg;
    assign result.position    = pos_reg;
    assign result.entry_count = count_reg;
    assign result.entry       = ent_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cap_reg      <= MAX_COUNT;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            ins_pos_reg  <= '0;
            ok_reg       <= 1'b0;
            sh_left_reg  <= '0;
            wpend_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cap_reg   <= cfg_wr_data;
                count_reg <= '0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        scan_idx_reg <= '0;
                        pend_reg     <= 1'b0;
                        found_reg    <= 1'b0;
                        ins_pos_reg  <= '0;
                    end
                end
                ST_SCAN:
                begin
                    pend_reg <= scan_issue;
                    if (scan_issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (less)
                    begin
                        ins_pos_reg <= ins_pos_reg + 1'b1;
                    end
                    if (scan_done)
                    begin
                        ok_reg    <= final_ok;
                        wpend_reg <= 1'b0;
                        if (cmd_reg == CMD_ADD)
                        begin
                            sh_left_reg <= count_reg - ins_pos_reg;
                        end
                        else
                        begin
                            sh_left_reg <= count_reg - {1'b0, found_pos_reg} - 1'b1;
                        end
                    end
                end
                ST_SHIFT:
                begin
                    wpend_reg <= sh_issue;
                    if (sh_issue)
                    begin
                        sh_left_reg <= sh_left_reg - 1'b1;
                    end
                    if (sh_done && (cmd_reg == CMD_REMOVE))
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                end
                ST_INSERT:
                begin
                    count_reg <= count_reg + 1'b1;
                end
                default:
                begin
                    pend_reg <= pend_reg;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_reg      <= cmd_t'(command);
                    id_reg       <= node_id;
                    hops_reg     <= hop_count;
                    slot_reg     <= slot;
                    ent_reg.id   <= EMPTY_MARK;
                    ent_reg.hops <= EMPTY_MARK;
                end
            end
            ST_SCAN:
            begin
                pend_idx_reg <= scan_idx_reg[IDX_W-1:0];
                if (hit)
                begin
                    found_pos_reg <= pend_idx_reg;
                    ent_reg       <= rd_data;
                end
                if (scan_done)
                begin
                    if (!final_ok)
                    begin
                        pos_reg <= '0;
                    end
                    else if (cmd_reg == CMD_ADD)
                    begin
                        pos_reg <= ins_pos_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        pos_reg <= found_pos_reg;
                    end
                    if (cmd_reg == CMD_ADD)
                    begin
                        ent_reg.id   <= add_ok ? id_reg : EMPTY_MARK;
                        ent_reg.hops <= add_ok ? hops_reg : EMPTY_MARK;
                        sh_src_reg   <= count_reg[IDX_W-1:0] - 1'b1;
                    end
                    else if (cmd_reg == CMD_REMOVE)
                    begin
                        // stays empty unless an entry slides down into the slot
                        ent_reg.id   <= EMPTY_MARK;
                        ent_reg.hops <= EMPTY_MARK;
                        sh_src_reg   <= found_pos_reg + 1'b1;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (sh_issue)
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        waddr_reg  <= sh_src_reg + 1'b1;
                        sh_src_reg <= sh_src_reg - 1'b1;
                    end
                    else
                    begin
                        waddr_reg  <= sh_src_reg - 1'b1;
                        sh_src_reg <= sh_src_reg + 1'b1;
                    end
                end
                if (wpend_reg && (waddr_reg == pos_reg) && (cmd_reg == CMD_REMOVE))
                begin
                    ent_reg <= rd_data;
                end
            end
            default:
            begin
                ent_reg <= ent_reg;
            end
        endcase
    end

endmodule

// ===== rtl/core/sorted_neighbor_table_core.sv =====
// Top level of the sorted neighbor table: sequencer, entry RAM, output register.
//
// Input channel (in_valid/in_stall) carries one command item: add, remove by
// id, find by id or read slot. Output channel (out_valid/out_stall) returns one
// result item per command: ok, position, entry_count, entry_id, entry_hops.
// The capacity register is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the block is idle, which the block itself does not
// enforce; a write empties the table. An accepted item first scans the stored
// entries, one RAM read per entry, then takes the last read word and settles
// (on an empty table it only settles). Add and remove then shift the entries
// behind the insert point or the removed entry at one entry per cycle and
// drain the last write; add then writes the new entry into its slot. The
// result is loaded into the output register once that is free; the entry
// count never exceeds 16. One item is in work at a time; in_stall is high while
// it is. The output register holds a finished item while out_stall is high;
// the next item is still accepted and runs until its result needs the register.
// Reset empties the table, sets capacity to 16 and clears out_valid; the RAM
// needs no clearing since only slots below the entry count are ever read.
module sorted_neighbor_table_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [snt_pkg::CNT_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 command,
    input  logic [snt_pkg::ID_W-1:0]   node_id,
    input  logic [snt_pkg::HOP_W-1:0]  hop_count,
    input  logic [snt_pkg::IDX_W-1:0]  slot,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       ok,
    output logic [snt_pkg::IDX_W-1:0]  position,
    output logic [snt_pkg::CNT_W-1:0]  entry_count,
    output logic [snt_pkg::ID_W-1:0]   entry_id,
    output logic [snt_pkg::HOP_W-1:0]  entry_hops
);
    import snt_pkg::*;

    mem_req_t mem_req;
    entry_t   rd_data;
    result_t  result;
    result_t  out_reg;
    logic     out_valid_reg;
    logic     res_load;
    logic     out_free;

    assign out_free = !out_valid_reg || !out_stall;

    snt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .node_id     (node_id),
        .hop_count   (hop_count),
        .slot        (slot),
        .out_free    (out_free),
        .res_load    (res_load),
        .result      (result),
        .mem_req     (mem_req),
        .rd_data     (rd_data)
    );

    snt_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = out_reg.ok;
    assign position    = out_reg.position;
    assign entry_count = out_reg.entry_count;
    assign entry_id    = out_reg.entry.id;
    assign entry_hops  = out_reg.entry.hops;

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (position == '0 && entry_id == EMPTY_MARK &&
                                entry_hops == EMPTY_MARK))
        else $error("failed result carries non-empty fields");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= MAX_COUNT))
        else $error("entry count above table size");

    a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
        else $error("RAM read and write hit the same entry");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block free right after taking an item");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !res_load)
        else $error("result loaded over a stalled item");

endmodule

// ===== dv/sorted_neighbor_table_core_tb.sv =====
// Self-checking testbench for sorted_neighbor_table_core: directed table, then random phases.
`timescale 1ns / 1ps

module sorted_neighbor_table_core_tb;
    import snt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 140;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [CNT_W-1:0] cfg_value;
        cmd_t             op;
        logic [ID_W-1:0]  id;
        logic [HOP_W-1:0] hops;
        logic [IDX_W-1:0] sl;
        result_t          exp;
    } row_t;

    localparam result_t FAIL_EMPTY = {1'b0, 4'd0, 5'd0, 8'hFF, 8'hFF};
    localparam result_t NO_EXP = '0;

    localparam int DIRECTED_ROWS = 27;
    localparam row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{ROW_TYPED,   5'd0,  CMD_READ,   8'd0,   8'd0,   4'd0,  FAIL_EMPTY},
        '{ROW_TYPED,   5'd0,  CMD_FIND,   8'd0,   8'd0,   4'd0,  FAIL_EMPTY},
        '{ROW_TYPED,   5'd0,  CMD_REMOVE, 8'hFF,  8'd0,   4'd0,  FAIL_EMPTY},
        '{ROW_TYPED,   5'd0,  CMD_ADD,    8'hFF,  8'd1,   4'd0,  FAIL_EMPTY},
        '{ROW_TYPED,   5'd0,  CMD_ADD,    8'd10,  8'd5,   4'd0,
          {1'b1, 4'd0, 5'd1, 8'd10, 8'd5}},
        // duplicate id with a different hop count
        '{ROW_TYPED,   5'd0,  CMD_ADD,    8'd10,  8'd3,   4'd0,
          {1'b0, 4'd0, 5'd1, 8'hFF, 8'hFF}},
        '{ROW_PREDICT, 5'd0,  CMD_ADD,    8'd0,   8'd0,   4'd0,  NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_ADD,    8'd254, 8'd254, 4'd0,  NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_ADD,    8'd3,   8'd255, 4'd0,  NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_ADD,    8'd7,   8'd5,   4'd0,  NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_ADD,    8'd12,  8'd5,   4'd0,  NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_FIND,   8'd12,  8'd0,   4'd0,  NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_READ,   8'd0,   8'd0,   4'd15, NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_READ,   8'd0,   8'd0,   4'd5,  NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_REMOVE, 8'd7,   8'd0,   4'd0,  NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_REMOVE, 8'd7,   8'd0,   4'd0,  NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_FIND,   8'hFF,  8'd0,   4'd0,  NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_REMOVE, 8'd0,   8'd0,   4'd0,  NO_EXP},
        '{ROW_PREDICT, 5'd0,  CMD_REMOVE, 8'd3,   8'd0,   4'd0,  NO_EXP},
        '{ROW_CFG,     5'd1,  CMD_ADD,    8'd0,   8'd0,   4'd0,  NO_EXP},
        '{ROW_TYPED,   5'd0,  CMD_ADD,    8'd200, 8'd170, 4'd0,
          {1'b1, 4'd0, 5'd1, 8'd200, 8'd170}},
        // table full at capacity one
        '{ROW_TYPED,   5'd0,  CMD_ADD,    8'd85,  8'd85,  4'd0,
          {1'b0, 4'd0, 5'd1, 8'hFF, 8'hFF}},
        '{ROW_TYPED,   5'd0,  CMD_READ,   8'd0,   8'd0,   4'd0,
          {1'b1, 4'd0, 5'd1, 8'd200, 8'd170}},
        '{ROW_CFG,     5'd0,  CMD_ADD,    8'd0,   8'd0,   4'd0,  NO_EXP},
        '{ROW_TYPED,   5'd0,  CMD_ADD,    8'd1,   8'd1,   4'd0,  FAIL_EMPTY},
        '{ROW_CFG,     5'd31, CMD_ADD,    8'd0,   8'd0,   4'd0,  NO_EXP},
        '{ROW_TYPED,   5'd0,  CMD_READ,   8'd0,   8'd0,   4'd0,  FAIL_EMPTY}
    };

    localparam logic [CNT_W-1:0] PHASE_CAPACITY [0:8] = '{
        5'd16, 5'd31, 5'd1, 5'd0, 5'd4, 5'd16, 5'd16, 5'd2, 5'd15
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]  cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        command = CMD_ADD;
    logic [ID_W-1:0]   node_id = '0;
    logic [HOP_W-1:0]  hop_count = '0;
    logic [IDX_W-1:0]  slot = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              ok;
    logic [IDX_W-1:0]  position;
    logic [CNT_W-1:0]  entry_count;
    logic [ID_W-1:0]   entry_id;
    logic [HOP_W-1:0]  entry_hops;

    // table copy kept by the predictor
    logic [ID_W-1:0]   nbr_id [MAX_ENTRIES];
    logic [HOP_W-1:0]  nbr_hops [MAX_ENTRIES];
    logic [CNT_W-1:0]  nbr_count;
    logic [CNT_W-1:0]  nbr_capacity;

    result_t expected_results [$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      no_idle = 1'b0;

    sorted_neighbor_table_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .node_id     (node_id),
        .hop_count   (hop_count),
        .slot        (slot),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .position    (position),
        .entry_count (entry_count),
        .entry_id    (entry_id),
        .entry_hops  (entry_hops)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic clear_table();
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            nbr_id[i] = EMPTY_MARK;
            nbr_hops[i] = EMPTY_MARK;
        end
        nbr_count = '0;
    endtask

    // Applies one command to the table copy and returns the result it yields.
    function automatic result_t apply_table_op(input cmd_t op, input logic [ID_W-1:0] id,
                                               input logic [HOP_W-1:0] hops,
                                               input logic [IDX_W-1:0] sl);
        int      usable;
        int      hit;
        int      p;
        int      i;
        logic    hit_ok;
        result_t r;
        usable = (nbr_capacity > MAX_COUNT) ? MAX_ENTRIES : int'(nbr_capacity);
        hit = nbr_count;
        for (i = int'(nbr_count) - 1; i >= 0; i--)
            if (nbr_id[i] == id)
                hit = i;
        p = 0;
        hit_ok = 1'b0;
        case (op)
            CMD_ADD:
            begin
                if (id != EMPTY_MARK && nbr_count < usable && hit == nbr_count)
                begin
                    while (p < nbr_count && (nbr_hops[p] < hops ||
                           (nbr_hops[p] == hops && nbr_id[p] < id)))
                        p++;
                    for (i = nbr_count; i > p; i--)
                    begin
                        nbr_id[i] = nbr_id[i-1];
                        nbr_hops[i] = nbr_hops[i-1];
                    end
                    nbr_id[p] = id;
                    nbr_hops[p] = hops;
                    nbr_count++;
                    hit_ok = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (id != EMPTY_MARK && hit < nbr_count)
                begin
                    for (i = hit; i + 1 < nbr_count; i++)
                    begin
                        nbr_id[i] = nbr_id[i+1];
                        nbr_hops[i] = nbr_hops[i+1];
                    end
                    nbr_id[nbr_count-1] = EMPTY_MARK;
                    nbr_hops[nbr_count-1] = EMPTY_MARK;
                    nbr_count--;
                    p = hit;
                    hit_ok = 1'b1;
                end
            end
            CMD_FIND:
            begin
                p = hit;
                hit_ok = (id != EMPTY_MARK && hit < nbr_count);
            end
            default:
            begin
                p = sl;
                hit_ok = (sl < nbr_count);
            end
        endcase
        if (!hit_ok)
            p = 0;
        r.ok = hit_ok;
        r.position = p[IDX_W-1:0];
        r.entry_count = nbr_count;
        r.entry.id = hit_ok ? nbr_id[p] : EMPTY_MARK;
        r.entry.hops = hit_ok ? nbr_hops[p] : EMPTY_MARK;
        return r;
    endfunction

    task automatic send_item(input cmd_t op, input logic [ID_W-1:0] id,
                             input logic [HOP_W-1:0] hops, input logic [IDX_W-1:0] sl,
                             input logic use_typed, input result_t typed_exp);
        result_t predicted;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= op;
        node_id <= id;
        hop_count <= hops;
        slot <= sl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // typed rows still run the predictor so the table copy stays in step
        predicted = apply_table_op(op, id, hops, sl);
        expected_results.push_back(use_typed ? typed_exp : predicted);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        nbr_capacity = value;
        clear_table();
    endtask

    task automatic report_mismatch(input string field, input int exp_val, input int act_val);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
        error_count++;
    endtask

    always @(negedge clk)
        out_stall <= !no_idle && ($urandom_range(0, 99) < 38);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result item with nothing expected, actual ok %0d pos %0d",
                         $time, ok, position);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (ok !== want.ok)
                    report_mismatch("ok", want.ok, ok);
                if (position !== want.position)
                    report_mismatch("position", want.position, position);
                if (entry_count !== want.entry_count)
                    report_mismatch("entry_count", want.entry_count, entry_count);
                if (entry_id !== want.entry.id)
                    report_mismatch("entry_id", want.entry.id, entry_id);
                if (entry_hops !== want.entry.hops)
                    report_mismatch("entry_hops", want.entry.hops, entry_hops);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** sorted_neighbor_table_core: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        cmd_t             op;
        logic [ID_W-1:0]  id;
        logic [HOP_W-1:0] hops;
        logic [IDX_W-1:0] sl;
        logic [CNT_W-1:0] cap;
        int               add_pct;
        int               pick;
        nbr_capacity = MAX_COUNT;
        clear_table();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_CFG)
                write_capacity(DIRECTED[r].cfg_value);
            else
                send_item(DIRECTED[r].op, DIRECTED[r].id, DIRECTED[r].hops, DIRECTED[r].sl,
                          DIRECTED[r].kind == ROW_TYPED, DIRECTED[r].exp);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            cap = (ph < 9) ? PHASE_CAPACITY[ph] : CNT_W'($urandom_range(0, 31));
            write_capacity(cap);
            no_idle = (ph == 5 || ph == 6);
            add_pct = (ph % 2) ? 55 : 35;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < add_pct)
                    op = CMD_ADD;
                else if (pick < add_pct + 20)
                    op = CMD_REMOVE;
                else if (pick < add_pct + 35)
                    op = CMD_FIND;
                else
                    op = CMD_READ;

                // small id pool so duplicates and hits are common
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    id = ID_W'($urandom_range(0, 23));
                else if (pick < 85)
                    id = ID_W'($urandom_range(0, 255));
                else if (pick < 92)
                    id = EMPTY_MARK;
                else
                    id = 8'd254;
                if ((op == CMD_REMOVE || op == CMD_FIND) && nbr_count != 0 &&
                    $urandom_range(0, 3) != 0)
                    id = nbr_id[$urandom_range(0, nbr_count - 1)];

                pick = $urandom_range(0, 99);
                if (pick < 50)
                    hops = HOP_W'($urandom_range(0, 7));
                else if (pick < 90)
                    hops = HOP_W'($urandom_range(0, 255));
                else
                    hops = HOP_W'(254 + $urandom_range(0, 1));

                if (nbr_count != 0 && $urandom_range(0, 9) < 7)
                    sl = IDX_W'($urandom_range(0, nbr_count - 1));
                else
                    sl = IDX_W'($urandom_range(0, 15));

                send_item(op, id, hops, sl, 1'b0, NO_EXP);
            end
        end
        no_idle = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("** sorted_neighbor_table_core: PASSED **");
        else
            $display("** sorted_neighbor_table_core: FAILED **");
        $finish;
    end

endmodule
